// ===== hw/rtl/pip_pkg.sv =====
package pip_pkg;

    // coordinate width, fixed by the payload format
    localparam int COORD_BITS = 16;
    localparam int VERTEX_MAX_DEF = 64;

    // configuration register indexes
    localparam logic [1:0] REG_VERTEX_COUNT = 2'd0;
    localparam logic [1:0] REG_RAY_END_X    = 2'd1;

    // item kinds
    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    typedef struct packed {
        logic                         kind;
        logic [5:0]                   vertex_index;
        logic signed [COORD_BITS-1:0] coord_x;
        logic signed [COORD_BITS-1:0] coord_y;
    } in_item_t;

    typedef struct packed {
        logic       inside_res;
        logic       on_boundary;
        logic [7:0] crossing_count;
    } out_item_t;

endpackage

// ===== hw/rtl/pip_vtx_mem.sv =====
module pip_vtx_mem #(
    parameter int DEPTH = pip_pkg::VERTEX_MAX_DEF,
    parameter int AW    = $clog2(pip_pkg::VERTEX_MAX_DEF),
    parameter int WIDTH = 2 * pip_pkg::COORD_BITS
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/point_in_polygon_ray_test.sv =====
// channel  | signals                     | direction | payload
// ---------+-----------------------------+-----------+----------------------------
// in       | in_valid, in_stall, in_data | to block  | kind, vertex_index, x, y
// out      | out_valid, out_stall, out_data | from block | inside, boundary, count
// cfg      | cfg_we, cfg_index, cfg_wdata | to block | vertex_count, ray_end_x
//
// a vertex item is written on its transfer without stalling the input; a query
// first fills the vertex window (FILL), then one shared 17x17 multiplier forms
// three products per edge, one per cycle, before an evaluate step; with n = 0
// the query goes straight to DONE. The next input transfer comes at the earliest
// in the cycle after the result transfer.
// reset (rst_n low, asynchronous) clears control and vertex_count and sets
// ray_end_x to the most negative value; vertex storage is undefined until written.
// in_stall is high from query transfer until its result transfers; a result
// waits in the output register for as long as out_stall holds.
module point_in_polygon_ray_test #(
    parameter int VERTEX_MAX = pip_pkg::VERTEX_MAX_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  pip_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output pip_pkg::out_item_t  out_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_wdata
);

    localparam int XW = pip_pkg::COORD_BITS;
    localparam int DW = XW + 1;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 1;
    localparam int AW = $clog2(VERTEX_MAX);
    localparam int NW = $clog2(VERTEX_MAX + 1);

    typedef enum logic [1:0] {IDLE, FILL, EDGE, DONE} state_t;

    state_t                state_reg;
    logic [6:0]            vcount_reg;
    logic signed [XW-1:0]  ray_x_reg;
    logic [NW-1:0]         n_reg;
    logic signed [XW-1:0]  px_reg, py_reg, rx_reg;
    logic [AW-1:0]         rd_addr_reg;
    logic [2:0]            fill_reg;
    logic [1:0]            step_reg;
    logic [NW-1:0]         edge_reg;
    logic signed [XW-1:0]  wx_reg [4];
    logic signed [XW-1:0]  wy_reg [4];
    logic signed [PW-1:0]  prod_reg, a_reg, b_reg;
    logic [7:0]            count_reg;
    logic                  parity_reg;
    logic                  bnd_reg;
    logic                  out_valid_reg;

    logic                  in_xfer;
    logic                  wr_en;
    logic                  rd_en;
    logic [2*XW-1:0]       rdata;
    logic [NW-1:0]         n_sat;
    logic                  rd_last;
    logic                  shift_en;

    assign in_xfer = in_valid && !in_stall;
    assign wr_en   = in_xfer && (in_data.kind == pip_pkg::KIND_VERTEX)
                     && (32'(in_data.vertex_index) < 32'(VERTEX_MAX));
    assign n_sat   = (32'(vcount_reg) > 32'(VERTEX_MAX)) ? NW'(VERTEX_MAX) : NW'(vcount_reg);
    assign rd_last = (NW'(rd_addr_reg) == n_reg - NW'(1));
    assign rd_en   = ((state_reg == FILL) && (fill_reg < 3'd4))
                     || ((state_reg == EDGE) && (step_reg == 2'd0));
    assign shift_en = ((state_reg == FILL) && (fill_reg != 3'd0))
                      || ((state_reg == EDGE) && (step_reg == 2'd3));

    pip_vtx_mem #(
        .DEPTH (VERTEX_MAX),
        .AW    (AW),
        .WIDTH (2 * XW)
    ) u_mem (
        .clk   (clk),
        .we    (wr_en),
        .waddr (AW'(in_data.vertex_index)),
        .wdata ({in_data.coord_x, in_data.coord_y}),
        .re    (rd_en),
        .raddr (rd_addr_reg),
        .rdata (rdata)
    );

    // window: k = 0, j = 1, m = 2, h = 3
    logic signed [XW-1:0] xj, yj, xm, ym, yk, yh;
    assign yk = wy_reg[0];
    assign xj = wx_reg[1];
    assign yj = wy_reg[1];
    assign xm = wx_reg[2];
    assign ym = wy_reg[2];
    assign yh = wy_reg[3];

    // shared multiplier operand select
    logic signed [DW-1:0] op_a, op_b;
    logic signed [PW-1:0] prod;
    always_comb
    begin
        case (step_reg)
            2'd0:
            begin
                op_a = DW'(px_reg) - DW'(xj);
                op_b = DW'(ym) - DW'(yj);
            end
            2'd1:
            begin
                op_a = DW'(py_reg) - DW'(yj);
                op_b = DW'(xm) - DW'(xj);
            end
            default:
            begin
                op_a = DW'(rx_reg) - DW'(xj);
                op_b = DW'(ym) - DW'(yj);
            end
        endcase
    end
    assign prod = PW'(op_a) * PW'(op_b);

    // edge evaluation, products a, b, c ready in step 3
    logic signed [SW-1:0] d_ba, d_bc;
    logic signed [DW-1:0] dyj, dym, dyk, dyh, rdx;
    logic                 collinear, in_box, o1, o2, o3, o4, horiz_hit, cross_hit;
    logic [1:0]           inc;
    always_comb
    begin
        d_ba = SW'(b_reg) - SW'(a_reg);
        d_bc = SW'(b_reg) - SW'(prod_reg);
        dyj  = DW'(yj) - DW'(py_reg);
        dym  = DW'(ym) - DW'(py_reg);
        dyk  = DW'(yk) - DW'(py_reg);
        dyh  = DW'(yh) - DW'(py_reg);
        rdx  = DW'(rx_reg) - DW'(px_reg);
        collinear = (a_reg == b_reg);
        in_box = (((xj <= xm) ? (xj <= px_reg && px_reg <= xm)
                              : (xm <= px_reg && px_reg <= xj))
               && ((yj <= ym) ? (yj <= py_reg && py_reg <= ym)
                              : (ym <= py_reg && py_reg <= yj)));
        // orientation signs, zero counts as positive
        o1 = (rdx == '0) || (dyj == '0) || (rdx[DW-1] == dyj[DW-1]);
        o2 = (rdx == '0) || (dym == '0) || (rdx[DW-1] == dym[DW-1]);
        o3 = !d_ba[SW-1];
        o4 = !d_bc[SW-1];
        cross_hit = (o1 != o2) && (o3 != o4);
        horiz_hit = (dyj == '0) && (dym == '0) && (dyk != '0) && (dyh != '0)
                    && (dyk[DW-1] != dyh[DW-1]);
        inc = collinear ? 2'd0 : (2'(horiz_hit) + 2'(cross_hit));
    end

    logic [8:0] count_sum;
    assign count_sum = 9'(count_reg) + 9'(inc);

    // sequencer, config and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            vcount_reg    <= '0;
            ray_x_reg     <= {1'b1, {(XW-1){1'b0}}};
            out_valid_reg <= 1'b0;
            fill_reg      <= '0;
            step_reg      <= '0;
            edge_reg      <= '0;
            count_reg     <= '0;
            parity_reg    <= 1'b0;
            bnd_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    pip_pkg::REG_VERTEX_COUNT: vcount_reg <= cfg_wdata[6:0];
                    pip_pkg::REG_RAY_END_X:    ray_x_reg  <= XW'(cfg_wdata);
                    default: ;
                endcase
            end
            case (state_reg)
                IDLE:
                begin
                    if (in_xfer && (in_data.kind == pip_pkg::KIND_QUERY))
                    begin
                        count_reg  <= '0;
                        parity_reg <= 1'b0;
                        bnd_reg    <= 1'b0;
                        fill_reg   <= '0;
                        step_reg   <= '0;
                        edge_reg   <= '0;
                        if (n_sat == '0)
                        begin
                            state_reg     <= DONE;
                            out_valid_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= FILL;
                        end
                    end
                end
                FILL:
                begin
                    fill_reg <= fill_reg + 3'd1;
                    if (fill_reg == 3'd4)
                    begin
                        state_reg <= EDGE;
                    end
                end
                EDGE:
                begin
                    step_reg <= step_reg + 2'd1;
                    if (step_reg == 2'd3)
                    begin
                        count_reg  <= count_sum[8] ? 8'hFF : count_sum[7:0];
                        parity_reg <= parity_reg ^ inc[0];
                        if (collinear && in_box)
                        begin
                            bnd_reg <= 1'b1;
                        end
                        edge_reg <= edge_reg + NW'(1);
                        if (edge_reg == n_reg - NW'(1))
                        begin
                            state_reg     <= DONE;
                            out_valid_reg <= 1'b1;
                        end
                    end
                end
                DONE:
                begin
                    if (!out_stall)
                    begin
                        state_reg     <= IDLE;
                        out_valid_reg <= 1'b0;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    // query operands, read address, window and products
    always_ff @(posedge clk)
    begin
        if (in_xfer && (in_data.kind == pip_pkg::KIND_QUERY))
        begin
            px_reg      <= in_data.coord_x;
            py_reg      <= in_data.coord_y;
            rx_reg      <= ray_x_reg;
            n_reg       <= n_sat;
            rd_addr_reg <= AW'(n_sat - NW'(1));
        end
        else if (rd_en)
        begin
            rd_addr_reg <= rd_last ? '0 : rd_addr_reg + AW'(1);
        end
        if (shift_en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                wx_reg[i] <= wx_reg[i+1];
                wy_reg[i] <= wy_reg[i+1];
            end
            wx_reg[3] <= rdata[2*XW-1:XW];
            wy_reg[3] <= rdata[XW-1:0];
        end
        if (state_reg == EDGE)
        begin
            prod_reg <= prod;
            if (step_reg == 2'd1)
            begin
                a_reg <= prod_reg;
            end
            if (step_reg == 2'd2)
            begin
                b_reg <= prod_reg;
            end
        end
    end

    assign in_stall  = (state_reg != IDLE);
    assign out_valid = out_valid_reg;
    assign out_data.inside_res     = bnd_reg || parity_reg;
    assign out_data.on_boundary    = bnd_reg;
    assign out_data.crossing_count = count_reg;

    // checks
    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while a result is pending");

    a_edge_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == EDGE) |-> (edge_reg < n_reg))
        else $error("edge counter past vertex count");

    a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == EDGE && step_reg == 2'd3 && edge_reg == n_reg - NW'(1))
        |=> out_valid)
        else $error("result not presented after last edge");

    a_fill_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FILL) |-> (fill_reg <= 3'd4))
        else $error("window fill overran");

endmodule
